// File: hw/rtl/vector_normalize_magnitude_macros.svh
// Assertion macros shared by the vector normalize / magnitude RTL.
`ifndef VECTOR_NORMALIZE_MAGNITUDE_MACROS_SVH
`define VECTOR_NORMALIZE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VNM_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("vnm: implication check failed");

// Fixed-delay implication, n is an elaboration constant.
`define VNM_ASSERT_LAT(label, a, n, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
    else $error("vnm: latency check failed");

`endif

// File: hw/rtl/vnm_pkg.sv
// Shared types and constants for the vector normalize / magnitude block.
package vnm_pkg;

  localparam int LANES      = 4;
  localparam int KIND_W     = 3;
  localparam int UNIT_W     = 32;
  localparam int UNIT_SHIFT = 30;
  localparam int SCALE_W    = 31;
  localparam int SQ_W       = 2 * SCALE_W;
  localparam int NSUM_W     = 64;
  localparam int NROOT_W    = 32;
  localparam int NUM_W      = SCALE_W + UNIT_SHIFT + 1;
  localparam int QUO_W      = 31;
  localparam int DIV_LAT    = QUO_W + 1;

  localparam logic [KIND_W-1:0] KIND_MIN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAX = 3'd4;
  localparam logic [QUO_W-1:0]  UNIT_ONE = QUO_W'(1) << UNIT_SHIFT;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_KIND = 2'd1,
    STAT_ZERO_VEC = 2'd2
  } status_t;

  typedef enum logic {
    OP_NORMALIZE = 1'b0,
    OP_MAGNITUDE = 1'b1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic zero;
  } ctrl_t;

endpackage

// File: hw/rtl/vnm_lane_front.sv
// One component lane: absolute value with kind masking, then its square.
module vnm_lane_front import vnm_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] comp,
  input  logic                 used,
  output logic [CW-1:0]        mag_o,
  output logic [2*CW-1:0]      sq_o,
  output logic                 neg_o
);

  logic [CW-1:0]   comp_u;
  logic [CW-1:0]   mag1_r;
  logic            neg1_r;
  logic [CW-1:0]   mag2_r;
  logic [2*CW-1:0] sq2_r;
  logic            neg2_r;

  assign comp_u = CW'(comp);

  always_ff @(posedge clk) begin
    neg1_r <= comp_u[CW-1];
    if (!used) begin
      mag1_r <= '0;
    end else if (comp_u[CW-1]) begin
      mag1_r <= CW'(0) - comp_u;
    end else begin
      mag1_r <= comp_u;
    end
    sq2_r  <= (2*CW)'(mag1_r) * (2*CW)'(mag1_r);
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
  end

  assign mag_o = mag2_r;
  assign sq_o  = sq2_r;
  assign neg_o = neg2_r;

endmodule

// File: hw/rtl/vnm_sqrt.sv
// Pipelined restoring square root, one root bit per stage, with sideband.
module vnm_sqrt import vnm_pkg::*; #(
  parameter int IN_W   = 65,
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [IN_W-1:0]   out_rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int TW = IN_W + 2;

  logic              vld_r  [ROOT_W];
  logic [IN_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int B = ROOT_W - 1 - g;
    logic              vld_i;
    logic [IN_W-1:0]   rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SIDE_W-1:0] side_i;
    logic [TW-1:0]     trial;
    logic              take;

    if (g == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = in_rad;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign side_i = side_r[g-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = (TW'(root_i) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_i) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_i;
      end
      rem_r[g]  <= take ? (rem_i - trial[IN_W-1:0]) : rem_i;
      root_r[g] <= take ? (root_i | (ROOT_W'(1) << B)) : root_i;
      side_r[g] <= side_i;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_rem  = rem_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// File: hw/rtl/vnm_div_lane.sv
// One normalize lane: rounded restoring division of the scaled magnitude by the length.
module vnm_div_lane import vnm_pkg::*; (
  input  logic               clk,
  input  logic [SCALE_W-1:0] in_mag,
  input  logic               in_neg,
  input  logic [NROOT_W-1:0] in_root,
  output logic [QUO_W-1:0]   out_quo,
  output logic               out_neg
);

  logic [NUM_W-1:0]   num_r;
  logic [NROOT_W-1:0] den_r;
  logic               neg_r;

  logic [NUM_W-1:0]   rem_r [QUO_W];
  logic [NROOT_W-1:0] dv_r  [QUO_W];
  logic [QUO_W-1:0]   quo_r [QUO_W];
  logic               sg_r  [QUO_W];

  always_ff @(posedge clk) begin
    num_r <= NUM_W'({in_mag, {UNIT_SHIFT{1'b0}}}) + NUM_W'(in_root >> 1);
    den_r <= (in_root == '0) ? NROOT_W'(1) : in_root;
    neg_r <= in_neg;
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int B = QUO_W - 1 - g;
    logic [NUM_W-1:0]   rem_i;
    logic [NROOT_W-1:0] dv_i;
    logic [QUO_W-1:0]   quo_i;
    logic               sg_i;
    logic [NUM_W-1:0]   trial;
    logic               take;

    if (g == 0) begin : g_first
      assign rem_i = num_r;
      assign dv_i  = den_r;
      assign quo_i = '0;
      assign sg_i  = neg_r;
    end else begin : g_next
      assign rem_i = rem_r[g-1];
      assign dv_i  = dv_r[g-1];
      assign quo_i = quo_r[g-1];
      assign sg_i  = sg_r[g-1];
    end

    assign trial = NUM_W'(dv_i) << B;
    assign take  = rem_i >= trial;

    always_ff @(posedge clk) begin
      rem_r[g] <= take ? (rem_i - trial) : rem_i;
      quo_r[g] <= take ? (quo_i | (QUO_W'(1) << B)) : quo_i;
      dv_r[g]  <= dv_i;
      sg_r[g]  <= sg_i;
    end
  end

  assign out_quo = quo_r[QUO_W-1];
  assign out_neg = sg_r[QUO_W-1];

endmodule

// File: hw/rtl/vector_normalize_magnitude.sv
// Top level of the 2D/3D/4D vector normalize and magnitude pipeline.
// Fully pipelined: one request per clock, busy is always low, and every request
// gives exactly one result on out_valid. The pipeline holds the two
// bit-per-stage square roots (COMP_WIDTH + 1 stages for the length, 32 for the
// normalize length) and the 32-stage dividers, one per component lane. The
// receiver cannot stall, so a result must be taken in the one cycle its strobe
// is high. Magnitude gives the rounded length in the input format; normalize
// gives Q1.30 unit components.
`include "vector_normalize_magnitude_macros.svh"

module vector_normalize_magnitude import vnm_pkg::*; #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [KIND_W-1:0]            in_vector_kind,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  input  logic signed [COMP_WIDTH-1:0] in_comp_w,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [COMP_WIDTH:0]          out_length,
  output logic signed [UNIT_W-1:0]     out_unit_x,
  output logic signed [UNIT_W-1:0]     out_unit_y,
  output logic signed [UNIT_W-1:0]     out_unit_z,
  output logic signed [UNIT_W-1:0]     out_unit_w
);

  localparam int CW     = COMP_WIDTH;
  localparam int SUM_W  = 2 * CW + 1;
  localparam int LEN_W  = CW + 1;
  localparam int BL_W   = $clog2(CW + 1);
  localparam int EXT_W  = CW + SCALE_W;
  localparam int CTRL_W = $bits(ctrl_t);
  localparam int LAT    = 3 + LEN_W + 4 + NROOT_W + DIV_LAT + 1;

  localparam int MS_MX   = LANES * CW;
  localparam int MS_NEG  = MS_MX + CW;
  localparam int MS_CTRL = MS_NEG + LANES;
  localparam int MS_W    = MS_CTRL + CTRL_W;

  localparam int NS_NEG  = LANES * SCALE_W;
  localparam int NS_LEN  = NS_NEG + LANES;
  localparam int NS_CTRL = NS_LEN + LEN_W;
  localparam int NS_W    = NS_CTRL + CTRL_W;

  localparam logic signed [UNIT_W-1:0] UNIT_POS = UNIT_W'(UNIT_ONE);
  localparam logic signed [UNIT_W-1:0] UNIT_NEG = UNIT_W'(0) - UNIT_W'(UNIT_ONE);

  logic                 accept;
  logic                 kind_ok;
  logic signed [CW-1:0] comp [LANES];
  logic                 used [LANES];

  logic                 vld1_r, vld2_r;
  ctrl_t                ctrl1_r, ctrl2_r;

  logic [CW-1:0]        mag2 [LANES];
  logic [2*CW-1:0]      sq2  [LANES];
  logic                 neg2 [LANES];

  // merge stage
  logic [SUM_W-1:0]     sum_c;
  logic [CW-1:0]        mx_c;
  logic                 vld3_r;
  ctrl_t                ctrl3_r;
  logic [SUM_W-1:0]     sum3_r;
  logic [CW-1:0]        mx3_r;
  logic [CW-1:0]        mag3_r [LANES];
  logic [LANES-1:0]     neg3_r;

  logic [MS_W-1:0]      ms_side_in, ms_side;
  logic                 ms_vld;
  logic [LEN_W-1:0]     ms_root;
  logic [SUM_W-1:0]     ms_rem;

  // length rounding and leading-one search
  logic [BL_W-1:0]      bl_c;
  logic [CW-1:0]        ms_mx;
  logic                 vldl_r;
  ctrl_t                ctrll_r;
  logic [LEN_W-1:0]     lenl_r;
  logic [BL_W-1:0]      bll_r;
  logic [CW-1:0]        magl_r [LANES];
  logic [LANES-1:0]     negl_r;

  logic                 vlds_r, vldq_r, vldu_r;
  ctrl_t                ctrls_r, ctrlq_r, ctrlu_r;
  logic [LEN_W-1:0]     lens_r, lenq_r, lenu_r;
  logic [LANES-1:0]     negs_r, negq_r, negu_r;
  logic [SCALE_W-1:0]   sms_r [LANES];
  logic [SCALE_W-1:0]   smq_r [LANES];
  logic [SCALE_W-1:0]   smu_r [LANES];
  logic [SQ_W-1:0]      sqq_r [LANES];
  logic [NSUM_W-1:0]    s2u_r;
  logic [NSUM_W-1:0]    s2_c;

  logic [NS_W-1:0]      ns_side_in, ns_side;
  logic                 ns_vld;
  logic [NROOT_W-1:0]   ns_root;

  logic [QUO_W-1:0]     quo   [LANES];
  logic                 qneg  [LANES];

  logic                 dl_vld_r  [DIV_LAT];
  ctrl_t                dl_ctrl_r [DIV_LAT];
  logic [LEN_W-1:0]     dl_len_r  [DIV_LAT];

  logic                 out_valid_r;
  status_t              status_nxt;
  logic [1:0]           out_status_r;
  logic [LEN_W-1:0]     out_length_r;
  logic signed [UNIT_W-1:0] unit_nxt   [LANES];
  logic signed [UNIT_W-1:0] out_unit_r [LANES];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign kind_ok = (in_vector_kind >= KIND_MIN) && (in_vector_kind <= KIND_MAX);

  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;
  assign comp[3] = in_comp_w;

  for (genvar i = 0; i < LANES; i++) begin : g_front
    assign used[i] = in_vector_kind > KIND_W'(i);
    vnm_lane_front #(.CW(CW)) u_front (
      .clk   (clk),
      .comp  (comp[i]),
      .used  (used[i]),
      .mag_o (mag2[i]),
      .sq_o  (sq2[i]),
      .neg_o (neg2[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= accept;
      vld2_r <= vld1_r;
    end
    ctrl1_r.op   <= op_t'(in_op);
    ctrl1_r.bad  <= !kind_ok;
    ctrl1_r.zero <= 1'b0;
    ctrl2_r      <= ctrl1_r;
  end

  always_comb begin
    sum_c = '0;
    mx_c  = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_c = sum_c + SUM_W'(sq2[i]);
      if (mag2[i] > mx_c) begin
        mx_c = mag2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    ctrl3_r.op   <= ctrl2_r.op;
    ctrl3_r.bad  <= ctrl2_r.bad;
    ctrl3_r.zero <= (mx_c == '0);
    sum3_r       <= sum_c;
    mx3_r        <= mx_c;
    for (int i = 0; i < LANES; i++) begin
      mag3_r[i] <= mag2[i];
      neg3_r[i] <= neg2[i];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ms_side_in[i*CW +: CW] = mag3_r[i];
    end
    ms_side_in[MS_MX +: CW]       = mx3_r;
    ms_side_in[MS_NEG +: LANES]   = neg3_r;
    ms_side_in[MS_CTRL +: CTRL_W] = ctrl3_r;
  end

  vnm_sqrt #(.IN_W(SUM_W), .ROOT_W(LEN_W), .SIDE_W(MS_W)) u_len_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld3_r),
    .in_rad   (sum3_r),
    .in_side  (ms_side_in),
    .out_vld  (ms_vld),
    .out_root (ms_root),
    .out_rem  (ms_rem),
    .out_side (ms_side)
  );

  assign ms_mx = ms_side[MS_MX +: CW];

  always_comb begin
    bl_c = '0;
    for (int k = 0; k < CW; k++) begin
      if (ms_mx[k]) begin
        bl_c = BL_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldl_r <= 1'b0;
    end else begin
      vldl_r <= ms_vld;
    end
    ctrll_r <= ctrl_t'(ms_side[MS_CTRL +: CTRL_W]);
    // round to nearest: bump when S > r*(r+1)
    lenl_r  <= ms_root + LEN_W'(ms_rem > SUM_W'(ms_root));
    bll_r   <= bl_c;
    negl_r  <= ms_side[MS_NEG +: LANES];
    for (int i = 0; i < LANES; i++) begin
      magl_r[i] <= ms_side[i*CW +: CW];
    end
  end

  // scale so the largest magnitude lands in [2^30, 2^31), then square and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlds_r <= 1'b0;
      vldq_r <= 1'b0;
      vldu_r <= 1'b0;
    end else begin
      vlds_r <= vldl_r;
      vldq_r <= vlds_r;
      vldu_r <= vldq_r;
    end
    ctrls_r <= ctrll_r;
    lens_r  <= lenl_r;
    negs_r  <= negl_r;
    ctrlq_r <= ctrls_r;
    lenq_r  <= lens_r;
    negq_r  <= negs_r;
    ctrlu_r <= ctrlq_r;
    lenu_r  <= lenq_r;
    negu_r  <= negq_r;
    s2u_r   <= s2_c;
    for (int i = 0; i < LANES; i++) begin
      sms_r[i] <= SCALE_W'(EXT_W'({magl_r[i], {SCALE_W{1'b0}}}) >> bll_r);
      sqq_r[i] <= SQ_W'(sms_r[i]) * SQ_W'(sms_r[i]);
      smq_r[i] <= sms_r[i];
      smu_r[i] <= smq_r[i];
    end
  end

  always_comb begin
    s2_c = '0;
    for (int i = 0; i < LANES; i++) begin
      s2_c = s2_c + NSUM_W'(sqq_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ns_side_in[i*SCALE_W +: SCALE_W] = smu_r[i];
    end
    ns_side_in[NS_NEG +: LANES]   = negu_r;
    ns_side_in[NS_LEN +: LEN_W]   = lenu_r;
    ns_side_in[NS_CTRL +: CTRL_W] = ctrlu_r;
  end

  vnm_sqrt #(.IN_W(NSUM_W), .ROOT_W(NROOT_W), .SIDE_W(NS_W)) u_norm_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vldu_r),
    .in_rad   (s2u_r),
    .in_side  (ns_side_in),
    .out_vld  (ns_vld),
    .out_root (ns_root),
    .out_rem  (),
    .out_side (ns_side)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vnm_div_lane u_div (
      .clk     (clk),
      .in_mag  (ns_side[i*SCALE_W +: SCALE_W]),
      .in_neg  (ns_side[NS_NEG + i]),
      .in_root (ns_root),
      .out_quo (quo[i]),
      .out_neg (qneg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dl_vld_r[k] <= 1'b0;
      end
    end else begin
      dl_vld_r[0] <= ns_vld;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl_vld_r[k] <= dl_vld_r[k-1];
      end
    end
    dl_ctrl_r[0] <= ctrl_t'(ns_side[NS_CTRL +: CTRL_W]);
    dl_len_r[0]  <= ns_side[NS_LEN +: LEN_W];
    for (int k = 1; k < DIV_LAT; k++) begin
      dl_ctrl_r[k] <= dl_ctrl_r[k-1];
      dl_len_r[k]  <= dl_len_r[k-1];
    end
  end

  always_comb begin
    priority if (dl_ctrl_r[DIV_LAT-1].bad) begin
      status_nxt = STAT_BAD_KIND;
    end else if (dl_ctrl_r[DIV_LAT-1].op == OP_NORMALIZE && dl_ctrl_r[DIV_LAT-1].zero) begin
      status_nxt = STAT_ZERO_VEC;
    end else begin
      status_nxt = STAT_OK;
    end
    for (int i = 0; i < LANES; i++) begin
      logic [UNIT_W-1:0] u;
      u = UNIT_W'((quo[i] > UNIT_ONE) ? UNIT_ONE : quo[i]);
      if (status_nxt != STAT_OK || dl_ctrl_r[DIV_LAT-1].op != OP_NORMALIZE) begin
        unit_nxt[i] = '0;
      end else if (qneg[i]) begin
        unit_nxt[i] = UNIT_W'(0) - u;
      end else begin
        unit_nxt[i] = u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dl_vld_r[DIV_LAT-1];
    end
    out_status_r <= status_nxt;
    out_length_r <= (status_nxt == STAT_OK && dl_ctrl_r[DIV_LAT-1].op == OP_MAGNITUDE)
                    ? dl_len_r[DIV_LAT-1] : '0;
    for (int i = 0; i < LANES; i++) begin
      out_unit_r[i] <= unit_nxt[i];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;
  assign out_unit_x = out_unit_r[0];
  assign out_unit_y = out_unit_r[1];
  assign out_unit_z = out_unit_r[2];
  assign out_unit_w = out_unit_r[3];

  `VNM_ASSERT_LAT(a_req_latency, start && !busy, LAT, out_valid)
  `VNM_ASSERT_IMP(a_bad_kind_zero, out_valid && out_status == STAT_BAD_KIND, out_length == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_unit_w == '0)
  `VNM_ASSERT_IMP(a_zero_vec_zero, out_valid && out_status == STAT_ZERO_VEC, out_length == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_unit_w == '0)
  `VNM_ASSERT_IMP(a_len_excl_unit, out_valid && out_length != '0, out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_unit_w == '0)
  `VNM_ASSERT_IMP(a_unit_range, out_valid, out_unit_x <= UNIT_POS && out_unit_x >= UNIT_NEG && out_unit_w <= UNIT_POS && out_unit_w >= UNIT_NEG)

endmodule
